FILE: hw/rtl/abms_pkg.sv
// abms_pkg: widths, request codes and controller/datapath interface structs
// for the adjacency bit matrix store. Depends on nothing.

package abms_pkg;

   localparam int CMD_W            = 3;
   localparam int VTX_W            = 6;
   localparam int VTX_SPAN         = 1 << VTX_W;
   localparam int VCNT_W           = 7;
   localparam int DEG_W            = 6;
   localparam int EDGE_W           = 11;
   localparam int REQ_DATA_W       = 16;
   localparam int RSP_DATA_W       = 40;
   localparam int MAX_VERTICES_DEF = 64;

   localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(64);
   localparam logic [DEG_W-1:0]  DEG_MAX      = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_EDGE   = 3'd0,
      CMD_DEL_EDGE   = 3'd1,
      CMD_DEL_VERTEX = 3'd2,
      CMD_EDGE_QUERY = 3'd3,
      CMD_DEGREE     = 3'd4,
      CMD_EXISTS     = 3'd5,
      CMD_TOTALS     = 3'd6
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // take the request in, apply rebuild
      logic rd_pair;   // read rows/degrees of both endpoints
      logic rd_idx;    // read row/degree at the walk index
      logic res_eval;  // form the result of a single-step request
      logic wr_a;      // write back endpoint a
      logic wr_b;      // write back endpoint b, update edge count
      logic wr_scan;   // clear the removed vertex from the row at the walk index
      logic vtx_drop;  // retire the removed vertex
      logic idx_clr;   // restart walk index and totals
      logic idx_inc;   // advance walk index
      logic tot_acc;   // accumulate totals for the walk index
      logic res_tot;   // put totals into the result
      logic out_load;  // move result to the response register
   } abms_ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    b_live;
      logic    edge_upd;
      logic    idx_last;
      logic    out_free;
   } abms_stat_type;

endpackage

FILE: hw/rtl/abms_ctrl.sv
// abms_ctrl: request sequencer of the adjacency bit matrix store.
// Depends on abms_pkg; drives the datapath abms_dpath through abms_ctl_type.

module abms_ctrl
   import abms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  abms_stat_type stat,
   output abms_ctl_type  ctl
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_LOOK     = 11'b000_0000_0010,
      ST_EVAL     = 11'b000_0000_0100,
      ST_WR_B     = 11'b000_0000_1000,
      ST_SCAN_RD  = 11'b000_0001_0000,
      ST_SCAN_WR  = 11'b000_0010_0000,
      ST_SCAN_END = 11'b000_0100_0000,
      ST_TOT_RD   = 11'b000_1000_0000,
      ST_TOT_ACC  = 11'b001_0000_0000,
      ST_TOT_END  = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            ctl.rd_pair = 1'b1;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            ctl.res_eval = 1'b1;
            state_in     = ST_DONE;
            case (stat.cmd)
               CMD_ADD_EDGE, CMD_DEL_EDGE: begin
                  if (stat.edge_upd) begin
                     ctl.wr_a = 1'b1;
                     state_in = ST_WR_B;
                  end
               end
               CMD_DEL_VERTEX: begin
                  if (stat.b_live) begin
                     ctl.idx_clr = 1'b1;
                     state_in    = ST_SCAN_RD;
                  end
               end
               CMD_TOTALS: begin
                  ctl.idx_clr = 1'b1;
                  state_in    = ST_TOT_RD;
               end
               default: ;
            endcase
         end
         ST_WR_B: begin
            ctl.wr_b = 1'b1;
            state_in = ST_DONE;
         end
         ST_SCAN_RD: begin
            ctl.rd_idx = 1'b1;
            state_in   = ST_SCAN_WR;
         end
         ST_SCAN_WR: begin
            ctl.wr_scan = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_SCAN_END;
            end else begin
               ctl.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SCAN_END: begin
            ctl.vtx_drop = 1'b1;
            state_in     = ST_DONE;
         end
         ST_TOT_RD: begin
            ctl.rd_idx = 1'b1;
            state_in   = ST_TOT_ACC;
         end
         ST_TOT_ACC: begin
            ctl.tot_acc = 1'b1;
            if (stat.idx_last) begin
               state_in = ST_TOT_END;
            end else begin
               ctl.idx_inc = 1'b1;
               state_in    = ST_TOT_RD;
            end
         end
         ST_TOT_END: begin
            ctl.res_tot = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> state_ff == ST_LOOK)
      else $error("accepted request did not start the lookup");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.capture, ctl.wr_a, ctl.wr_b, ctl.wr_scan, ctl.vtx_drop}))
      else $error("overlapping storage updates");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_WR && stat.idx_last) |=> state_ff == ST_SCAN_END)
      else $error("vertex removal walk overran the last vertex");

   a_wr_b_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR_B |-> $past(ctl.wr_a))
      else $error("second endpoint written without the first");

endmodule

FILE: hw/rtl/abms_dpath.sv
// abms_dpath: adjacency rows, degree memory, live mask, counters and the
// response register of the adjacency bit matrix store. Depends on abms_pkg.

module abms_dpath
   import abms_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic [VCNT_W-1:0]     csr_wdata,
   input  abms_ctl_type          ctl,
   output abms_stat_type         stat
);

   localparam int NV = (MAX_VERTICES < VTX_SPAN) ? MAX_VERTICES : VTX_SPAN;
   localparam int VW = $clog2(NV);
   localparam logic [VTX_W:0] NV_L     = (VTX_W + 1)'(NV);
   localparam logic [VW-1:0]  IDX_LAST = VW'(NV - 1);

   typedef struct packed {
      logic [DEG_W-1:0]  most;
      logic [DEG_W-1:0]  least;
      logic [EDGE_W-1:0] edges;
      logic [VCNT_W-1:0] live;
      logic [DEG_W-1:0]  degree;
      logic              found;
      logic              status;
   } res_type;

   // request registers
   cmd_type          cmd_ff;
   logic [VTX_W-1:0] va_ff, vb_ff;

   // storage
   logic [NV-1:0]    row_mem [NV];
   logic [DEG_W-1:0] deg_mem [NV];
   logic [NV-1:0]    vld_ff;
   logic [NV-1:0]    live_ff;
   logic [EDGE_W-1:0] edge_ff;
   logic [VCNT_W-1:0] vcnt_ff;

   // read ports
   logic [NV-1:0]    row0_q, row1_q;
   logic [DEG_W-1:0] deg0_q, deg1_q;
   logic             vld0_q, vld1_q;
   logic [NV-1:0]    row0, row1;
   logic [DEG_W-1:0] deg0, deg1;

   // walk and totals
   logic [VW-1:0]     idx_ff;
   logic [VCNT_W-1:0] cnt_ff;
   logic [DEG_W-1:0]  lo_ff, hi_ff;

   res_type res_ff, res_in, out_ff;
   logic    rsp_vld_ff;

   logic [VTX_W-1:0] req_va, req_vb;
   logic             req_rebuild;
   logic [VW-1:0]    a_idx, b_idx, rd0_addr, wr_addr, flip_idx;
   logic             a_live, b_live, edge_bit, rd0_en;
   logic             wr_en, wr_set;
   logic [NV-1:0]    base_row, flip_bit, wr_row;
   logic [DEG_W-1:0] base_deg, wr_deg;
   logic [NV-1:0]    fill_mask, fill_rst;

   assign req_va      = req_tdata[VTX_W-1:0];
   assign req_vb      = req_tdata[2*VTX_W-1:VTX_W];
   assign req_rebuild = req_tdata[2*VTX_W];

   assign a_idx = va_ff[VW-1:0];
   assign b_idx = vb_ff[VW-1:0];

   assign a_live = ({1'b0, va_ff} < NV_L) && live_ff[a_idx];
   assign b_live = ({1'b0, vb_ff} < NV_L) && live_ff[b_idx];

   // unwritten entries read as zero
   assign row0 = vld0_q ? row0_q : '0;
   assign row1 = vld1_q ? row1_q : '0;
   assign deg0 = vld0_q ? deg0_q : '0;
   assign deg1 = vld1_q ? deg1_q : '0;

   assign edge_bit = row0[b_idx];

   always_comb begin
      for (int i = 0; i < NV; i++) begin
         fill_mask[i] = (vcnt_ff > VCNT_W'(i));
         fill_rst[i]  = (VCOUNT_RESET > VCNT_W'(i));
      end
   end

   // read port 0: endpoint a or walk index; port 1: endpoint b
   assign rd0_en   = ctl.rd_pair | ctl.rd_idx;
   assign rd0_addr = ctl.rd_pair ? a_idx : idx_ff;

   // write port
   assign wr_en    = ctl.wr_a | ctl.wr_b | (ctl.wr_scan & row0[b_idx]);
   assign wr_addr  = ctl.wr_a ? a_idx : (ctl.wr_b ? b_idx : idx_ff);
   assign flip_idx = ctl.wr_b ? a_idx : b_idx;
   assign wr_set   = (cmd_ff == CMD_ADD_EDGE) && !ctl.wr_scan;
   assign base_row = ctl.wr_b ? row1 : row0;
   assign base_deg = ctl.wr_b ? deg1 : deg0;

   always_comb begin
      flip_bit           = '0;
      flip_bit[flip_idx] = 1'b1;
   end

   assign wr_row = wr_set ? (base_row | flip_bit) : (base_row & ~flip_bit);
   assign wr_deg = wr_set ? (base_deg + DEG_W'(1)) : (base_deg - DEG_W'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
         deg_mem[wr_addr] <= wr_deg;
      end
      if (rd0_en) begin
         row0_q <= row_mem[rd0_addr];
         deg0_q <= deg_mem[rd0_addr];
         vld0_q <= vld_ff[rd0_addr];
      end
      if (ctl.rd_pair) begin
         row1_q <= row_mem[b_idx];
         deg1_q <= deg_mem[b_idx];
         vld1_q <= vld_ff[b_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= cmd_type'(req_tuser);
         va_ff  <= req_va;
         vb_ff  <= req_vb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff <= VCOUNT_RESET;
      end else if (csr_valid) begin
         vcnt_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         live_ff <= fill_rst;
         edge_ff <= '0;
      end else if (ctl.capture && req_rebuild) begin
         vld_ff  <= '0;
         live_ff <= fill_mask;
         edge_ff <= '0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.wr_b) begin
            edge_ff <= wr_set ? (edge_ff + EDGE_W'(1)) : (edge_ff - EDGE_W'(1));
         end
         if (ctl.vtx_drop) begin
            vld_ff[b_idx]  <= 1'b0;
            live_ff[b_idx] <= 1'b0;
            edge_ff        <= edge_ff - EDGE_W'(deg1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (ctl.idx_clr) begin
         idx_ff <= '0;
      end else if (ctl.idx_inc) begin
         idx_ff <= idx_ff + VW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.idx_clr) begin
         cnt_ff <= '0;
         lo_ff  <= DEG_MAX;
         hi_ff  <= '0;
      end else if (ctl.tot_acc && live_ff[idx_ff]) begin
         cnt_ff <= cnt_ff + VCNT_W'(1);
         if (deg0 < lo_ff) begin
            lo_ff <= deg0;
         end
         if (deg0 > hi_ff) begin
            hi_ff <= deg0;
         end
      end
   end

   always_comb begin
      res_in = '0;
      case (cmd_ff)
         CMD_ADD_EDGE:   res_in.status = (va_ff != vb_ff) && !(a_live && b_live);
         CMD_DEL_EDGE:   res_in.status = !(a_live && b_live);
         CMD_DEL_VERTEX: res_in.status = !b_live;
         CMD_EDGE_QUERY: res_in.found  = a_live && b_live && edge_bit;
         CMD_DEGREE: begin
            res_in.status = !b_live;
            res_in.degree = b_live ? deg1 : '0;
         end
         CMD_EXISTS:     res_in.found  = b_live;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.res_eval) begin
         res_ff <= res_in;
      end else if (ctl.res_tot) begin
         res_ff.live  <= cnt_ff;
         res_ff.edges <= edge_ff;
         res_ff.least <= (cnt_ff == '0) ? '0 : lo_ff;
         res_ff.most  <= hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(res_type)){1'b0}}, out_ff};

   assign stat.cmd      = cmd_ff;
   assign stat.b_live   = b_live;
   assign stat.edge_upd = ((cmd_ff == CMD_ADD_EDGE) || (cmd_ff == CMD_DEL_EDGE)) &&
                          a_live && b_live && (va_ff != vb_ff) &&
                          ((cmd_ff == CMD_ADD_EDGE) ? !edge_bit : edge_bit);
   assign stat.idx_last = (idx_ff == IDX_LAST);
   assign stat.out_free = !rsp_vld_ff || rsp_tready;

endmodule

FILE: hw/rtl/adjacency_bit_matrix_store.sv
// Adjacency bit matrix store, top level. A request runs through the states LOOK and EVAL,
// then DONE; an edge add/remove that changes the matrix also writes row b in WR_B, and
// vertex removal of a live vertex and totals walk every vertex through read port 0.
// One request at a time; a stall on rsp holds the result in DONE. Reset (synchronous,
// active high): vertex_count back to 64, edges cleared via valid bits. Uses abms_pkg,
// abms_ctrl, abms_dpath.

module adjacency_bit_matrix_store
   import abms_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CMD_W-1:0]      req_tuser,  // [2:0] cmd
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [5:0] vertex_a, [11:6] vertex_b,
                                             // [12] rebuild, [15:13] zero
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] status, [1] found, [7:2] vertex_degree,
                                             // [14:8] live_vertices, [25:15] edge_total,
                                             // [31:26] least_degree, [37:32] most_degree,
                                             // [39:38] zero
   // vertex_count register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [VCNT_W-1:0]     csr_wdata
);

   abms_ctl_type  ctl;
   abms_stat_type stat;

   // The register is a plain flop: take every write at once.
   assign csr_ready = 1'b1;

   // Sequencer: one request at a time; accepts a new request as soon as
   // the previous result sits in the response register, even if it is not taken yet.
   abms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   // Storage and arithmetic: rows and degrees share one write port, endpoint
   // rows are read in pairs, edge updates write row a then row b.
   abms_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .stat       (stat)
   );

endmodule
